[rtl/assert_macros.svh]
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked on every rising edge outside reset
`define AMF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("amf assertion failed");
// property checked on every rising edge, reset included
`define AMF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("amf assertion failed");
`else
`define AMF_ASSERT(lbl, clk, rst_n, prop)
`define AMF_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/amf_pkg.sv]
package amf_pkg;

    localparam int CHASSIS_WIDTH   = 11;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 11;
    localparam int BOUND_WIDTH     = 11;

    typedef struct packed {
        logic              mode;
        logic              header_ok;
        logic [1:0]        aim_request;
        logic signed [15:0] velocity_x;
        logic signed [15:0] velocity_y;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               aim_mode;
        logic [CHASSIS_WIDTH-1:0] chassis_x;
        logic [CHASSIS_WIDTH-1:0] chassis_y;
        logic                     link_alive;
        logic                     frame_accepted;
    } t_out_item;

endpackage

[rtl/amf_scale.sv]
module amf_scale (
    input  logic signed [15:0]                       i_raw,
    input  logic [amf_pkg::BOUND_WIDTH-1:0]          i_min,
    input  logic [amf_pkg::BOUND_WIDTH-1:0]          i_max,
    output logic [amf_pkg::CHASSIS_WIDTH-1:0]        o_cmd
);
    import amf_pkg::*;

    // 1024 * 224, and the first numerator whose quotient exceeds 2047
    localparam logic signed [25:0] OFFSET  = 26'sd229376;
    localparam logic [24:0]        OVER    = 25'd458752;
    // floor(x / 7) == (x * RECIP_7) >> 17 for every x below 14336
    localparam logic [14:0]        RECIP_7 = 15'd18725;

    logic signed [25:0] w_raw;
    logic signed [25:0] w_num;
    logic [13:0]        w_x;
    logic [28:0]        w_prod;
    logic [11:0]        w_v;
    logic [11:0]        w_lo;
    logic [11:0]        w_clamp;

    // offset plus raw * 275 as shifts and adds
    assign w_raw = {{10{i_raw[15]}}, i_raw};
    assign w_num = OFFSET + (w_raw <<< 8) + (w_raw <<< 4) + (w_raw <<< 1) + w_raw;

    // divide by 224: drop the factor 32, then divide by 7
    assign w_x    = w_num[18:5];
    assign w_prod = {15'd0, w_x} * {14'd0, RECIP_7};

    always_comb begin
        if (w_num[25]) begin
            w_v = {1'b0, i_min};
        end else if (w_num[24:0] >= OVER) begin
            w_v = 12'd2048;
        end else begin
            w_v = {1'b0, w_prod[27:17]};
        end
    end

    assign w_lo    = (w_v < {1'b0, i_min}) ? {1'b0, i_min} : w_v;
    assign w_clamp = (w_lo > {1'b0, i_max}) ? {1'b0, i_max} : w_lo;
    assign o_cmd   = CHASSIS_WIDTH'(w_clamp[10:0]);

endmodule

[rtl/aim_mode_filter_with_link_watchdog_unit.sv]
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_stall    i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_stall  o_out_item (t_out_item)
// cfg       input      i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// one item a cycle while o_in_stall is low: each accepted item updates the state in the same cycle and
// its result is registered into the output register, or into the skid entry while the output is held
// reset is synchronous, active low, and loads the default register values
// a two-entry output stage (output register plus skid) keeps the input open
// while one result waits; o_in_stall rises only when both entries are full
module aim_mode_filter_with_link_watchdog_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  amf_pkg::t_in_item                     i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output amf_pkg::t_out_item                    o_out_item,
    input  logic                                  i_cfg_wr_en,
    input  logic [amf_pkg::CFG_INDEX_WIDTH-1:0]   i_cfg_index,
    input  logic [amf_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data
);
    import amf_pkg::*;

`include "assert_macros.svh"

    // aim mode codes
    localparam logic [1:0] AIM_IDLE  = 2'd0;
    localparam logic [1:0] AIM_FRONT = 2'd1;
    localparam logic [1:0] AIM_REAR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REAR_CONFIRM = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REAR_HOLD    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ALIVE_WINDOW = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CHASSIS_MIN  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CHASSIS_MAX  = 3'd4;

    localparam logic [CHASSIS_WIDTH-1:0] CHASSIS_NEUTRAL = CHASSIS_WIDTH'(1024);

    // configuration registers
    logic [7:0]             r_rear_confirm;
    logic [9:0]             r_rear_hold;
    logic [9:0]             r_alive_window;
    logic [BOUND_WIDTH-1:0] r_chassis_min;
    logic [BOUND_WIDTH-1:0] r_chassis_max;

    // filter and watchdog state
    logic [1:0]               r_aim, n_aim;
    logic [7:0]               r_confirm, n_confirm;
    logic [9:0]               r_rear_time, n_rear_time;
    logic [9:0]               r_tick_count, n_tick_count;
    logic                     r_frame_seen, n_frame_seen;
    logic                     r_alive, n_alive;
    logic [CHASSIS_WIDTH-1:0] r_last_x, n_last_x;
    logic [CHASSIS_WIDTH-1:0] r_last_y, n_last_y;

    // output stage
    t_out_item r_out, r_skid, n_result;
    logic      r_out_valid, r_skid_valid;

    logic                     w_in_fire;
    logic                     w_out_fire;
    logic                     w_frame_ok;
    logic [CHASSIS_WIDTH-1:0] w_cmd_x;
    logic [CHASSIS_WIDTH-1:0] w_cmd_y;
    logic [7:0]               w_confirm_inc;
    logic [10:0]              w_cap_wide;
    logic [9:0]               w_cap;
    logic [9:0]               w_rear_inc;
    logic [9:0]               w_tick_inc;

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_in_fire   = i_in_valid && !r_skid_valid;
    assign w_out_fire  = r_out_valid && !i_out_stall;
    assign w_frame_ok  = i_in_item.mode && i_in_item.header_ok;

    amf_scale u_scale_x (
        .i_raw (i_in_item.velocity_x),
        .i_min (r_chassis_min),
        .i_max (r_chassis_max),
        .o_cmd (w_cmd_x)
    );

    amf_scale u_scale_y (
        .i_raw (i_in_item.velocity_y),
        .i_min (r_chassis_min),
        .i_max (r_chassis_max),
        .o_cmd (w_cmd_y)
    );

    // saturating counters of the filter, and the tick increment of the watchdog
    assign w_confirm_inc = (r_confirm != 8'd255) ? r_confirm + 8'd1 : r_confirm;
    assign w_cap_wide    = {1'b0, r_rear_hold} + 11'd1;
    assign w_cap         = w_cap_wide[10] ? 10'd1023 : w_cap_wide[9:0];
    assign w_rear_inc    = (r_rear_time < w_cap) ? r_rear_time + 10'd1 : r_rear_time;
    assign w_tick_inc    = r_tick_count + 10'd1;

    always_comb begin
        n_aim        = r_aim;
        n_confirm    = r_confirm;
        n_rear_time  = r_rear_time;
        n_tick_count = r_tick_count;
        n_frame_seen = r_frame_seen;
        n_alive      = r_alive;
        n_last_x     = r_last_x;
        n_last_y     = r_last_y;

        if (!i_in_item.mode) begin
            // tick: advance the alive window, a window of zero acts as one
            n_tick_count = w_tick_inc;
            if (w_tick_inc >= r_alive_window) begin
                n_alive      = r_frame_seen;
                n_frame_seen = 1'b0;
                n_tick_count = 10'd0;
            end
        end else if (i_in_item.header_ok) begin
            n_frame_seen = 1'b1;
            n_last_x     = w_cmd_x;
            n_last_y     = w_cmd_y;
            unique case (r_aim)
                AIM_IDLE: begin
                    if (i_in_item.aim_request == AIM_FRONT) begin
                        n_aim     = AIM_FRONT;
                        n_confirm = 8'd0;
                    end else if (i_in_item.aim_request == AIM_REAR) begin
                        n_confirm = w_confirm_inc;
                        if (w_confirm_inc >= r_rear_confirm) begin
                            n_aim       = AIM_REAR;
                            n_rear_time = 10'd0;
                            n_confirm   = 8'd0;
                        end
                    end else begin
                        // idle or invalid request restarts the run
                        n_confirm = 8'd0;
                    end
                end
                AIM_FRONT: begin
                    if (i_in_item.aim_request == AIM_IDLE) begin
                        n_aim = AIM_IDLE;
                    end else if (i_in_item.aim_request != AIM_FRONT) begin
                        // rear or invalid request
                        n_aim       = AIM_REAR;
                        n_rear_time = 10'd0;
                    end
                end
                AIM_REAR: begin
                    n_rear_time = w_rear_inc;
                    if (i_in_item.aim_request == AIM_FRONT) begin
                        n_aim       = AIM_FRONT;
                        n_rear_time = 10'd0;
                    end else if (i_in_item.aim_request == AIM_IDLE) begin
                        // leave rear only after the minimum hold
                        if (w_rear_inc >= r_rear_hold) begin
                            n_aim       = AIM_IDLE;
                            n_rear_time = 10'd0;
                        end
                    end
                end
                default: begin
                    // unused state code falls back to idle
                    n_aim       = AIM_IDLE;
                    n_rear_time = 10'd0;
                    n_confirm   = 8'd0;
                end
            endcase
        end

        n_result.aim_mode       = n_aim;
        n_result.chassis_x      = n_last_x;
        n_result.chassis_y      = n_last_y;
        n_result.link_alive     = n_alive;
        n_result.frame_accepted = w_frame_ok;
    end

    // configuration writes, indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rear_confirm <= 8'd5;
            r_rear_hold    <= 10'd200;
            r_alive_window <= 10'd200;
            r_chassis_min  <= BOUND_WIDTH'(364);
            r_chassis_max  <= BOUND_WIDTH'(1684);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_REAR_CONFIRM: r_rear_confirm <= i_cfg_data[7:0];
                CFG_REAR_HOLD:    r_rear_hold    <= i_cfg_data[9:0];
                CFG_ALIVE_WINDOW: r_alive_window <= i_cfg_data[9:0];
                CFG_CHASSIS_MIN:  r_chassis_min  <= i_cfg_data[BOUND_WIDTH-1:0];
                CFG_CHASSIS_MAX:  r_chassis_max  <= i_cfg_data[BOUND_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // state update on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aim        <= AIM_IDLE;
            r_confirm    <= 8'd0;
            r_rear_time  <= 10'd0;
            r_tick_count <= 10'd0;
            r_frame_seen <= 1'b0;
            r_alive      <= 1'b0;
            r_last_x     <= CHASSIS_NEUTRAL;
            r_last_y     <= CHASSIS_NEUTRAL;
        end else if (w_in_fire) begin
            r_aim        <= n_aim;
            r_confirm    <= n_confirm;
            r_rear_time  <= n_rear_time;
            r_tick_count <= n_tick_count;
            r_frame_seen <= n_frame_seen;
            r_alive      <= n_alive;
            r_last_x     <= n_last_x;
            r_last_y     <= n_last_y;
        end
    end

    // output register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_fire;
            end
        end else if (w_in_fire) begin
            // output held by the consumer, park the new item
            r_skid_valid <= 1'b1;
        end
    end

    // payload of the output stage, no reset needed
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_fire) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_fire) begin
                r_out <= n_result;
            end
        end else if (w_in_fire) begin
            r_skid <= n_result;
        end
    end

    `AMF_ASSERT_ALWAYS(a_skid_behind_out, i_clk, r_skid_valid |-> r_out_valid)
    `AMF_ASSERT(a_park_on_stall, i_clk, i_rst_n, (w_in_fire && r_out_valid && i_out_stall) |=> r_skid_valid)
    `AMF_ASSERT_ALWAYS(a_rear_time_only_in_rear, i_clk, (r_aim != AIM_REAR) |-> (r_rear_time == 10'd0))
    `AMF_ASSERT_ALWAYS(a_confirm_only_in_idle, i_clk, (r_aim != AIM_IDLE) |-> (r_confirm == 8'd0))

endmodule
